// File: rtl/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared widths, command and status codes, and the cell control bundle
// for the indexed insert/delete list.
// ----------------------------------------------------------------------------
package ilst_pkg;

  // default list capacity
  localparam int ILST_DEPTH = 16;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     ins;  // shift up above pos, load val at pos
    logic                     del;  // shift down from pos upward
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
  } ilst_ctrl_t;

endpackage

// File: rtl/ilst_if.sv
// ----------------------------------------------------------------------------
// ilst_if
// Valid/ready channels for list commands and list results.
// ----------------------------------------------------------------------------
interface ilst_in_if
  import ilst_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface ilst_out_if
  import ilst_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] read_value;
  logic [COUNT_W-1:0]       element_count;

  modport source (output valid, status, read_value, element_count, input ready);
  modport sink   (input valid, status, read_value, element_count, output ready);
endinterface

// File: rtl/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Ordered list of up to DEPTH signed words kept in a row of slot cells;
// insert and delete shift every slot at or above the position at once.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid / ready | command, position, item_value
//  out_ch   | out | valid / ready | status, read_value, element_count
//
//  One command per cycle unless out_ch stalls: each command is decoded
//  against the count and applied to all slots in the cycle it is accepted;
//  its result sits in the output register on the next cycle.
//  in_ch.ready is high while the output register is empty or being taken.
//  Reset clears the count and the output valid; slot contents stay
//  undefined until written.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list
  import ilst_pkg::*;
#(
  parameter int DEPTH = ILST_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ilst_in_if.sink    in_ch,
  ilst_out_if.source out_ch
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic [STAT_W-1:0]        status_r;
  logic [STAT_W-1:0]        status_nxt;
  logic signed [WORD_W-1:0] read_value_r;
  logic signed [WORD_W-1:0] read_value_nxt;
  logic [COUNT_W-1:0]       elem_count_r;

  logic                     accept;
  logic [CMPW-1:0]          pos_x;
  logic [CMPW-1:0]          cnt_x;
  logic                     do_ins;
  logic                     do_del;
  logic signed [WORD_W-1:0] rd_word;
  ilst_ctrl_t               ctrl;

  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic signed [WORD_W-1:0] cell_tap  [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_x       = CMPW'(in_ch.position);
  assign cnt_x       = CMPW'(count_r);

  // command decode and status
  always_comb begin
    do_ins         = 1'b0;
    do_del         = 1'b0;
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    count_nxt      = count_r;
    case (in_ch.command)
      CMD_INSERT: begin
        if (count_r == CW'(DEPTH))  status_nxt = ST_FULL;
        else if (pos_x > cnt_x)     status_nxt = ST_BAD_POS;
        else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (count_r == '0)          status_nxt = ST_EMPTY;
        else if (pos_x >= cnt_x)    status_nxt = ST_BAD_POS;
        else begin
          do_del    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x)         status_nxt = ST_BAD_POS;
        else                        read_value_nxt = rd_word;
      end
      default: status_nxt = ST_BAD_POS;
    endcase
  end

  // broadcast to the slots
  always_comb begin
    ctrl.ins = accept && do_ins;
    ctrl.del = accept && do_del;
    ctrl.pos = in_ch.position;
    ctrl.val = in_ch.item_value;
  end

  // row of slots, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower_w;
    logic signed [WORD_W-1:0] upper_w;
    if (i == 0) begin : g_lo_edge
      assign lower_w = '0;
    end else begin : g_lo
      assign lower_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign upper_w = '0;
    end else begin : g_hi
      assign upper_w = cell_data[i+1];
    end
    ilst_cell #(
      .IDX  (i),
      .CMPW (CMPW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .lower_data (lower_w),
      .upper_data (upper_w),
      .data       (cell_data[i]),
      .rd_tap     (cell_tap[i])
    );
  end

  // read bus: at most one slot drives a nonzero tap
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | cell_tap[k];
    end
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      if (accept)            out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      read_value_r <= read_value_nxt;
      elem_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.read_value    = read_value_r;
  assign out_ch.element_count = elem_count_r;

endmodule

// File: rtl/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// One list slot. Holds a word and, on each command, keeps it, loads the
// inserted value, or takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module ilst_cell
  import ilst_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int CMPW = 5
) (
  input  logic                     clk,
  input  ilst_ctrl_t               ctrl,
  input  logic signed [WORD_W-1:0] lower_data,  // word of slot IDX-1
  input  logic signed [WORD_W-1:0] upper_data,  // word of slot IDX+1
  output logic signed [WORD_W-1:0] data,
  output logic signed [WORD_W-1:0] rd_tap       // data when pos hits, else 0
);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic [CMPW-1:0]          pos_x;
  logic [CMPW-1:0]          idx_x;
  logic                     hit;
  logic                     above;

  assign pos_x = CMPW'(ctrl.pos);
  assign idx_x = CMPW'(IDX);
  assign hit   = (pos_x == idx_x);
  assign above = (idx_x > pos_x);

  // slot update
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (hit)        data_nxt = ctrl.val;
      else if (above) data_nxt = lower_data;
    end else if (ctrl.del) begin
      if (hit || above) data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data   = data_r;
  assign rd_tap = hit ? data_r : '0;

endmodule

// File: rtl/ilst_chk.sv
// ----------------------------------------------------------------------------
// ilst_chk
// Port-level checks for the indexed insert/delete list, bound to the top.
// ----------------------------------------------------------------------------
module ilst_chk
  import ilst_pkg::*;
#(
  parameter int DEPTH = ILST_DEPTH
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        status,
  input logic signed [WORD_W-1:0] read_value,
  input logic [COUNT_W-1:0]       element_count
);

  // a result waiting on the sink holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(read_value) && $stable(element_count))
    else $error("result changed while stalled");

  // every accepted command yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no result");

  // failed commands report zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> read_value == '0)
    else $error("nonzero data with failing status");

  // empty status only with an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY) |-> element_count == '0)
    else $error("empty status with entries held");

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 31) || (int'(element_count) <= DEPTH))
    else $error("element count above capacity");

endmodule

bind indexed_insert_delete_list ilst_chk #(.DEPTH(DEPTH)) u_ilst_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .read_value    (out_ch.read_value),
  .element_count (out_ch.element_count)
);
